### design/flow_latency_stats_table_macros.svh
// ----------------------------------------------------------------------------
// Flow latency statistics table: assertion macros
// Shared concurrent assertion helpers. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FLOW_LATENCY_STATS_TABLE_MACROS_SVH
`define FLOW_LATENCY_STATS_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication check.
`define FLS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fls: same-cycle check failed");

// Next-cycle implication check.
`define FLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fls: next-cycle check failed");

`else

`define FLS_ASSERT_IMP(label, clk, rst, ante, cons)
`define FLS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/fls_pkg.sv
// ----------------------------------------------------------------------------
// Flow latency statistics table: package
// Command codes, entry layout and the queued command format.
// ----------------------------------------------------------------------------
package fls_pkg;

   // Widths fixed by the transaction format.
   localparam int CMD_W     = 2;
   localparam int INDEX_W   = 8;
   localparam int INDEX_SPAN = 2 ** INDEX_W;
   localparam int STAT_W    = 64;

   // Request command codes.
   localparam logic [CMD_W-1:0] CMD_REC_RX = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REC_TX = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic [STAT_W-1:0] U64_MAX = '1;

   // Operation after classification by the front end.
   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_RX    = 2'd1,
      OP_TX    = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // Statistics of one direction.
   typedef struct packed {
      logic [STAT_W-1:0] total;
      logic [STAT_W-1:0] count;
      logic [STAT_W-1:0] min;
      logic [STAT_W-1:0] max;
   } dir_type;

   // One table entry.
   typedef struct packed {
      dir_type rx;
      dir_type tx;
   } stats_type;

   // Command as it travels from the front end to the back end.
   typedef struct packed {
      op_type             op;
      logic               oob;
      logic [INDEX_W-1:0] index;
      logic [STAT_W-1:0]  delta;
   } cmd_type;

   // One result transaction.
   typedef struct packed {
      stats_type stats;
      logic      taken;
      logic      wrapped;
   } result_type;

   localparam dir_type   DIR_RESET   = '{total: '0, count: '0, min: U64_MAX, max: '0};
   localparam stats_type ENTRY_RESET = '{rx: DIR_RESET, tx: DIR_RESET};

endpackage

### design/fls_ram.sv
// ----------------------------------------------------------------------------
// Flow latency statistics table: generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module fls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/fls_front.sv
// ----------------------------------------------------------------------------
// Flow latency statistics table: front end
// Accepts request transactions, classifies them and holds them in a short
// queue until the back end takes them.
// ----------------------------------------------------------------------------
`include "flow_latency_stats_table_macros.svh"

module fls_front #(
   parameter int FLOW_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fls_pkg::CMD_W-1:0]     req_cmd,
   input  logic [fls_pkg::INDEX_W-1:0]   req_flow_index,
   input  logic [fls_pkg::STAT_W-1:0]    req_start_time,
   input  logic [fls_pkg::STAT_W-1:0]    req_end_time,
   output logic                          head_valid,
   output fls_pkg::cmd_type              head,
   input  logic                          head_pop
);

   import fls_pkg::*;

   localparam int QDEPTH = 2;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int CNT_W  = $clog2(QDEPTH + 1);
   localparam logic [16:0] FLOW_LIMIT = 17'(FLOW_COUNT);

   cmd_type          cls;
   cmd_type          slot_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push;

   // Classify the request: sample delay, range check and operation.
   always_comb begin
      cls.index = req_flow_index;
      cls.delta = req_end_time - req_start_time;
      cls.oob   = ({{(17 - INDEX_W){1'b0}}, req_flow_index} >= FLOW_LIMIT);
      case (req_cmd)
         CMD_REC_RX: cls.op = (req_start_time != '0) ? OP_RX : OP_READ;
         CMD_REC_TX: cls.op = (req_start_time != '0) ? OP_TX : OP_READ;
         CMD_READ:   cls.op = OP_READ;
         CMD_CLEAR:  cls.op = OP_CLEAR;
         default:    cls.op = OP_READ;
      endcase
   end

   // Queue control.
   assign req_stall = (cnt_ff == CNT_W'(QDEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !head_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && head_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   // The back end only takes a command that is there.
   `FLS_ASSERT_IMP(a_pop_not_empty, clock, reset, head_pop, cnt_ff != '0)

endmodule

### design/fls_back.sv
// ----------------------------------------------------------------------------
// Flow latency statistics table: back end
// Reads the addressed entry, applies the command, writes the entry back and
// loads the result register.
// ----------------------------------------------------------------------------
`include "flow_latency_stats_table_macros.svh"

module fls_back #(
   parameter int FLOW_COUNT = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  fls_pkg::cmd_type     head,
   output logic                 head_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fls_pkg::result_type  rsp
);

   import fls_pkg::*;

   localparam int DEPTH  = (FLOW_COUNT < INDEX_SPAN) ? FLOW_COUNT : INDEX_SPAN;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = $bits(stats_type);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      dir_type d;
      logic    wrap;
   } upd_type;

   state_type          state_ff, state_in;
   cmd_type            item_ff;
   logic [DEPTH-1:0]   valid_ff, valid_in;
   logic               hit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff;
   result_type         res;
   stats_type          cur;
   stats_type          nxt;
   upd_type            upd_rx;
   upd_type            upd_tx;
   logic               wr_en;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   logic [ENTRY_W-1:0] rd_data;

   // Adds one sample to the statistics of one direction.
   function automatic upd_type add_sample(dir_type d, logic [STAT_W-1:0] delta);
      upd_type          u;
      logic [STAT_W:0]  sum;
      sum       = {1'b0, d.total} + {1'b0, delta};
      u.d.total = sum[STAT_W-1:0];
      u.d.count = d.count + 1'b1;
      u.d.min   = (delta < d.min) ? delta : d.min;
      u.d.max   = (delta > d.max) ? delta : d.max;
      u.wrap    = sum[STAT_W];
      return u;
   endfunction

   // Take the next command when the result register will be free.
   assign head_pop = head_valid && (state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign rd_addr  = head.index[AW-1:0];
   assign wr_addr  = item_ff.index[AW-1:0];

   fls_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (nxt),
      .rd_en   (head_pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Entry update. An entry never written since reset reads as cleared.
   always_comb begin
      cur    = hit_ff ? stats_type'(rd_data) : ENTRY_RESET;
      upd_rx = add_sample(cur.rx, item_ff.delta);
      upd_tx = add_sample(cur.tx, item_ff.delta);
      nxt    = cur;
      res.taken   = 1'b0;
      res.wrapped = 1'b0;
      case (item_ff.op)
         OP_RX: begin
            nxt.rx      = upd_rx.d;
            res.taken   = 1'b1;
            res.wrapped = upd_rx.wrap;
         end
         OP_TX: begin
            nxt.tx      = upd_tx.d;
            res.taken   = 1'b1;
            res.wrapped = upd_tx.wrap;
         end
         OP_CLEAR: nxt = ENTRY_RESET;
         default:  nxt = cur;
      endcase
      res.stats = nxt;
      if (item_ff.oob) begin
         res.stats   = ENTRY_RESET;
         res.taken   = 1'b0;
         res.wrapped = 1'b0;
      end
      wr_en = (state_ff == S_EXEC) && !item_ff.oob && (item_ff.op != OP_READ);
   end

   // Sequencer, valid bits and result handshake.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  state_in = head_pop ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_EXEC) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Command and result payload registers.
   always_ff @(posedge clock) begin
      if (head_pop) begin
         item_ff <= head;
         hit_ff  <= valid_ff[rd_addr];
      end
      if (state_ff == S_EXEC) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // The result register is free whenever an update completes.
   `FLS_ASSERT_IMP(a_exec_out_free, clock, reset, state_ff == S_EXEC, !rsp_valid_ff)
   // Every completed update presents a result in the next cycle.
   `FLS_ASSERT_NEXT(a_exec_gives_rsp, clock, reset, state_ff == S_EXEC, rsp_valid_ff)
   // The store is written only while an update completes.
   `FLS_ASSERT_IMP(a_write_in_exec, clock, reset, wr_en, state_ff == S_EXEC)

endmodule

### design/flow_latency_stats_table.sv
// ----------------------------------------------------------------------------
// Flow latency statistics table: top level
// Per-flow receive and transmit delay statistics with record, read and clear.
// ----------------------------------------------------------------------------
// Usage: each request transaction carries a command, a flow index and two
// timestamps. Record commands add end_time - start_time to the receive or
// transmit statistics of the flow (a zero start_time records nothing), read
// returns the entry and clear restores it. Every request gives exactly one
// response transaction with the entry as it stands after the command.
// An accepted request is registered in the queue; when the back end is free
// it is taken into the command register as the RAM read starts, and the result
// register loads as the entry is written back. The back end takes no new
// command until the read-modify-write of the statistics RAM, whose read data
// is registered, is complete. A two-entry queue sits between the request side
// and the RAM sequencer, so requests keep arriving while a response waits.
// When the receiver stalls, the response holds; the queue then fills and
// req_stall rises. Reset clears the per-entry valid bits at once, so every
// entry reads as cleared; there is no clearing pass before requests are taken.
// ----------------------------------------------------------------------------
module flow_latency_stats_table #(
   parameter int FLOW_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [fls_pkg::CMD_W-1:0]     req_cmd,
   input  logic [fls_pkg::INDEX_W-1:0]   req_flow_index,
   input  logic [fls_pkg::STAT_W-1:0]    req_start_time,
   input  logic [fls_pkg::STAT_W-1:0]    req_end_time,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [fls_pkg::STAT_W-1:0]    rsp_rx_total,
   output logic [fls_pkg::STAT_W-1:0]    rsp_rx_samples,
   output logic [fls_pkg::STAT_W-1:0]    rsp_rx_min,
   output logic [fls_pkg::STAT_W-1:0]    rsp_rx_max,
   output logic [fls_pkg::STAT_W-1:0]    rsp_tx_total,
   output logic [fls_pkg::STAT_W-1:0]    rsp_tx_samples,
   output logic [fls_pkg::STAT_W-1:0]    rsp_tx_min,
   output logic [fls_pkg::STAT_W-1:0]    rsp_tx_max,
   output logic                          rsp_sample_taken,
   output logic                          rsp_total_wrapped
);

   import fls_pkg::*;

   logic       head_valid;
   cmd_type    head;
   logic       head_pop;
   result_type rsp;

   // Request side: classification and queue.
   fls_front #(
      .FLOW_COUNT (FLOW_COUNT)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_flow_index (req_flow_index),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .head_valid     (head_valid),
      .head           (head),
      .head_pop       (head_pop)
   );

   // Table side: read-modify-write and response register.
   fls_back #(
      .FLOW_COUNT (FLOW_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp)
   );

   // Response fields.
   assign rsp_rx_total      = rsp.stats.rx.total;
   assign rsp_rx_samples    = rsp.stats.rx.count;
   assign rsp_rx_min        = rsp.stats.rx.min;
   assign rsp_rx_max        = rsp.stats.rx.max;
   assign rsp_tx_total      = rsp.stats.tx.total;
   assign rsp_tx_samples    = rsp.stats.tx.count;
   assign rsp_tx_min        = rsp.stats.tx.min;
   assign rsp_tx_max        = rsp.stats.tx.max;
   assign rsp_sample_taken  = rsp.taken;
   assign rsp_total_wrapped = rsp.wrapped;

endmodule
